/* rtl/core/esd_pkg.sv */
package esd_pkg;

   // Character codes used by the decoder.
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_QUOTE     = 8'h27;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_SEVEN     = 8'h37;
   localparam logic [7:0] CHAR_A         = 8'h61;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_N         = 8'h6e;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_V         = 8'h76;

   localparam logic [7:0] CTRL_BEL = 8'd7;
   localparam logic [7:0] CTRL_BS  = 8'd8;
   localparam logic [7:0] CTRL_HT  = 8'd9;
   localparam logic [7:0] CTRL_LF  = 8'd10;
   localparam logic [7:0] CTRL_VT  = 8'd11;
   localparam logic [7:0] CTRL_FF  = 8'd12;
   localparam logic [7:0] CTRL_CR  = 8'd13;

   // Result queue: room for the two beats of one input plus two waiting.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      MODE_PLAIN = 3'b001,
      MODE_ESC   = 3'b010,
      MODE_OCT   = 3'b100
   } mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } rsp_payload_type;

   // Up to two result beats produced by one input beat.
   typedef struct packed {
      logic [1:0]                num;
      rsp_payload_type [1:0]     beat;
   } emit_type;

   typedef struct packed {
      logic       mode_plain;
      logic [7:0] octal_value;
   } dec_status_type;

   function automatic logic [7:0] map_escape(input logic [7:0] c);
      logic [7:0] r;
      unique case (c)
         CHAR_A:         r = CTRL_BEL;
         CHAR_B:         r = CTRL_BS;
         CHAR_F:         r = CTRL_FF;
         CHAR_N:         r = CTRL_LF;
         CHAR_R:         r = CTRL_CR;
         CHAR_T:         r = CTRL_HT;
         CHAR_V:         r = CTRL_VT;
         CHAR_QUOTE:     r = CHAR_QUOTE;
         CHAR_BACKSLASH: r = CHAR_BACKSLASH;
         default:        r = c;
      endcase
      return r;
   endfunction

endpackage

/* rtl/core/esd_decode.sv */
module esd_decode
   import esd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  req_payload_type req_data,
   output emit_type        emit,
   output dec_status_type  status
);

   mode_type   mode_ff, mode_in;
   logic [7:0] octal_ff, octal_in;

   always_comb begin
      logic [7:0] b;
      logic       plain;
      logic       is_digit;
      b        = req_data.in_byte;
      plain    = 1'b0;
      is_digit = (b >= CHAR_ZERO) && (b <= CHAR_SEVEN);
      mode_in  = mode_ff;
      octal_in = octal_ff;
      emit     = '0;

      unique case (mode_ff)
         MODE_ESC: begin
            if (b == CHAR_ZERO) begin
               mode_in  = MODE_OCT;
               octal_in = '0;
            end else begin
               emit.beat[0].out_byte = map_escape(b);
               emit.num              = 2'd1;
               mode_in               = MODE_PLAIN;
            end
         end
         MODE_OCT: begin
            if (is_digit) begin
               // Shifting out the top bits keeps the value modulo 256.
               octal_in = {octal_ff[4:0], b[2:0]};
            end else begin
               emit.beat[0].out_byte = octal_ff;
               emit.num              = 2'd1;
               octal_in              = '0;
               mode_in               = MODE_PLAIN;
               plain                 = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_PLAIN;
            plain   = 1'b1;
         end
      endcase

      if (plain) begin
         if (b == CHAR_BACKSLASH) begin
            mode_in = MODE_ESC;
         end else begin
            emit.beat[emit.num[0]].out_byte = b;
            emit.num                        = emit.num + 2'd1;
         end
      end

      if (req_data.in_last) begin
         if (mode_in == MODE_OCT) begin
            emit.beat[emit.num[0]].out_byte = octal_in;
            emit.num                        = emit.num + 2'd1;
         end
         mode_in  = MODE_PLAIN;
         octal_in = '0;
      end

      if (emit.num == 2'd2) begin
         emit.beat[1].run_last = 1'b1;
      end else if (emit.num == 2'd1) begin
         emit.beat[0].run_last = 1'b1;
      end

      if (!take) begin
         emit.num = 2'd0;
         mode_in  = mode_ff;
         octal_in = octal_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_PLAIN;
         octal_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         octal_ff <= octal_in;
      end
   end

   assign status.mode_plain  = (mode_ff == MODE_PLAIN);
   assign status.octal_value = octal_ff;

endmodule

/* rtl/core/esd_out_queue.sv */
module esd_out_queue
   import esd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  emit_type        emit,
   output logic            room,
   output logic [QCNT_W-1:0] fill,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   rsp_payload_type   entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign fill      = count_ff;
   // Two free entries are needed since one input beat may yield two results.
   assign room      = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(emit.num);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + QCNT_W'(emit.num) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (emit.num != 2'd0) begin
         entry_ff[wr_ptr_ff] <= emit.beat[0];
      end
      if (emit.num == 2'd2) begin
         entry_ff[wr_ptr_ff + QPTR_W'(1)] <= emit.beat[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/core/escape_sequence_decoder.sv */
// Channel | Dir | Handshake             | Beat
// req     | in  | req_valid/req_ready   | req_data: in_byte, in_last
// rsp     | out | rsp_valid/rsp_ready   | rsp_data: out_byte, run_last
//
// One input beat is decoded in the cycle it is accepted; its zero, one or two
// results are registered into the four-entry result queue. req_ready is high
// while the queue has at least two free entries, so with rsp_ready held high
// a beat is accepted every cycle until two-result beats leave more than two
// entries waiting.
// Reset (synchronous) returns to plain text mode and empties the queue.
// A stalled rsp side fills the queue and then holds off req.
module escape_sequence_decoder
   import esd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   logic              take;
   emit_type          emit;
   dec_status_type    status;
   logic [QCNT_W-1:0] fill;

   assign take = req_valid && req_ready;

   esd_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .req_data (req_data),
      .emit     (emit),
      .status   (status)
   );

   esd_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .room      (req_ready),
      .fill      (fill),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      fill <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      take && req_data.in_last |=> status.mode_plain && status.octal_value == 8'd0)
      else $error("decoder state not cleared after last byte");

   assert property (@(posedge clock) disable iff (reset)
      status.mode_plain |-> status.octal_value == 8'd0)
      else $error("octal value held outside an octal run");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed or dropped while stalled");

endmodule
